// File: rtl/core/ese_pkg.sv
`default_nettype none

package ese_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int KEY_W         = 32;
    localparam int TAG_W         = 16;
    localparam int PC_W          = 3;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    // register index, taken from paddr bit 2
    localparam logic REG_DESCENDING = 1'b0;

    // step addresses of the sequencer program
    localparam logic [PC_W-1:0] S_LOAD   = 3'd0;
    localparam logic [PC_W-1:0] S_ROWCHK = 3'd1;
    localparam logic [PC_W-1:0] S_HOLD   = 3'd2;
    localparam logic [PC_W-1:0] S_SCAN   = 3'd3;
    localparam logic [PC_W-1:0] S_ROWEND = 3'd4;
    localparam logic [PC_W-1:0] S_EMITI  = 3'd5;
    localparam logic [PC_W-1:0] S_EMIT   = 3'd6;
    localparam logic [PC_W-1:0] S_SPARE  = 3'd7;

    // read address sources
    localparam logic [1:0] RD_I  = 2'd0;
    localparam logic [1:0] RD_I1 = 2'd1;
    localparam logic [1:0] RD_J1 = 2'd2;
    localparam logic [1:0] RD_K  = 2'd3;

    // jump conditions
    localparam logic [2:0] C_ALWAYS  = 3'd0;
    localparam logic [2:0] C_LAST_IN = 3'd1;
    localparam logic [2:0] C_I_DONE  = 3'd2;
    localparam logic [2:0] C_J_DONE  = 3'd3;
    localparam logic [2:0] C_K_DONE  = 3'd4;

    typedef struct packed {
        logic            take_in;
        logic            init_ptrs;
        logic            load_hold;
        logic            set_j;
        logic            scan;
        logic            wr_row;
        logic            inc_i;
        logic            emit;
        logic [1:0]      rd_src;
        logic [2:0]      cond;
        logic [PC_W-1:0] jmp;
        logic [PC_W-1:0] nxt;
    } t_uop;

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '0;
        u.cond   = C_ALWAYS;
        u.rd_src = RD_I;
        u.jmp    = S_LOAD;
        u.nxt    = S_LOAD;
        case (pc)
            S_LOAD: begin
                u.take_in   = 1'b1;
                u.init_ptrs = 1'b1;
                u.cond      = C_LAST_IN;
                u.jmp       = S_ROWCHK;
                u.nxt       = S_LOAD;
            end
            S_ROWCHK: begin
                u.rd_src = RD_I;
                u.cond   = C_I_DONE;
                u.jmp    = S_EMITI;
                u.nxt    = S_HOLD;
            end
            S_HOLD: begin
                u.load_hold = 1'b1;
                u.set_j     = 1'b1;
                u.rd_src    = RD_I1;
                u.jmp       = S_SCAN;
            end
            S_SCAN: begin
                u.scan   = 1'b1;
                u.rd_src = RD_J1;
                u.cond   = C_J_DONE;
                u.jmp    = S_ROWEND;
                u.nxt    = S_SCAN;
            end
            S_ROWEND: begin
                u.wr_row = 1'b1;
                u.inc_i  = 1'b1;
                u.jmp    = S_ROWCHK;
            end
            S_EMITI: begin
                u.rd_src = RD_K;
                u.jmp    = S_EMIT;
            end
            S_EMIT: begin
                u.emit   = 1'b1;
                u.rd_src = RD_K;
                u.cond   = C_K_DONE;
                u.jmp    = S_LOAD;
                u.nxt    = S_EMIT;
            end
            default: begin
                u.jmp = S_LOAD;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/exchange_sort_engine_unit.sv
// Collects up to MAX_ITEMS requests (signed key plus tag) until one is marked last, sorts them
// in place with an exchange sort and sends them out in order, last marked, overflow flagged if
// requests were dropped for lack of room. The sort is run by a small microcoded sequencer over a
// one-write, one-read item memory: for each row i it checks the row, loads item i into a hold
// register, scans the later items with one compare per cycle, swapping when a pair is out of
// order, and writes the held item back to row i; a first read then starts the output. Results
// then leave at one per cycle while the receiver does not stall, through an output register,
// which lets loading of the next set start while the final result still waits. The sort order
// is set by the descending_order register at address 0.
`default_nettype none

module exchange_sort_engine_unit
    import ese_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_AW-1:0]        paddr,
    input  wire logic [APB_DW-1:0]        pwdata,
    output logic      [APB_DW-1:0]        prdata,
    output logic                          pready,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [KEY_W-1:0]  i_item_key,
    input  wire logic        [TAG_W-1:0]  i_item_tag,
    input  wire logic                     i_last_item,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [KEY_W-1:0]       o_sorted_key,
    output logic        [TAG_W-1:0]       o_sorted_tag,
    output logic                          o_last_result,
    output logic                          o_overflowed
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic signed [KEY_W-1:0] mem_key [MAX_ITEMS];
    logic        [TAG_W-1:0] mem_tag [MAX_ITEMS];

    logic [PC_W-1:0] r_pc, n_pc;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_ovf, n_ovf;
    logic            r_desc;
    logic [AW-1:0]   r_i, n_i;
    logic [AW-1:0]   r_j, n_j;
    logic [AW-1:0]   r_k, n_k;
    logic signed [KEY_W-1:0] r_hold_key, n_hold_key;
    logic        [TAG_W-1:0] r_hold_tag, n_hold_tag;
    logic signed [KEY_W-1:0] r_rd_key;
    logic        [TAG_W-1:0] r_rd_tag;

    logic                    r_ov, n_ov;
    logic signed [KEY_W-1:0] r_okey, n_okey;
    logic        [TAG_W-1:0] r_otag, n_otag;
    logic                    r_olast, n_olast;
    logic                    r_oovf, n_oovf;

    t_uop                    uop;
    logic                    in_acc;
    logic                    has_room;
    logic                    emit_adv;
    logic                    do_swap;
    logic                    take_jmp;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [KEY_W-1:0] wr_key;
    logic        [TAG_W-1:0] wr_tag;
    logic                    cfg_wr;

    assign uop        = uop_rom(r_pc);
    assign o_in_stall = !uop.take_in;
    assign in_acc     = i_in_valid && uop.take_in;
    assign has_room   = r_cnt < CW'(MAX_ITEMS);
    assign emit_adv   = uop.emit && (!r_ov || !i_out_stall);
    assign do_swap    = uop.scan && (r_desc ? (r_hold_key < r_rd_key)
                                            : (r_hold_key > r_rd_key));

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DESCENDING);
    assign prdata = (paddr[2] == REG_DESCENDING) ? {{(APB_DW-1){1'b0}}, r_desc} : '0;

    always_comb begin
        case (uop.rd_src)
            RD_I:    rd_addr = r_i;
            RD_I1:   rd_addr = r_i + AW'(1);
            RD_J1:   rd_addr = r_j + AW'(1);
            RD_K:    rd_addr = emit_adv ? (r_k + AW'(1)) : r_k;
            default: rd_addr = r_i;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cnt[AW-1:0];
        wr_key  = i_item_key;
        wr_tag  = i_item_tag;
        if (in_acc && has_room) begin
            wr_en = 1'b1;
        end else if (do_swap) begin
            wr_en   = 1'b1;
            wr_addr = r_j;
            wr_key  = r_hold_key;
            wr_tag  = r_hold_tag;
        end else if (uop.wr_row) begin
            wr_en   = 1'b1;
            wr_addr = r_i;
            wr_key  = r_hold_key;
            wr_tag  = r_hold_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[wr_addr] <= wr_key;
            mem_tag[wr_addr] <= wr_tag;
        end
        r_rd_key <= mem_key[rd_addr];
        r_rd_tag <= mem_tag[rd_addr];
    end

    always_comb begin
        case (uop.cond)
            C_ALWAYS:  take_jmp = 1'b1;
            C_LAST_IN: take_jmp = in_acc && i_last_item;
            C_I_DONE:  take_jmp = (CW'(r_i) + CW'(1)) >= r_cnt;
            C_J_DONE:  take_jmp = (CW'(r_j) + CW'(1)) == r_cnt;
            C_K_DONE:  take_jmp = emit_adv && ((CW'(r_k) + CW'(1)) == r_cnt);
            default:   take_jmp = 1'b1;
        endcase
        n_pc = take_jmp ? uop.jmp : uop.nxt;
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_hold_key = r_hold_key;
        n_hold_tag = r_hold_tag;
        n_ov       = r_ov;
        n_okey     = r_okey;
        n_otag     = r_otag;
        n_olast    = r_olast;
        n_oovf     = r_oovf;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        if (uop.init_ptrs) begin
            n_i = '0;
            n_k = '0;
        end
        if (in_acc) begin
            if (has_room) begin
                n_cnt = r_cnt + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (uop.load_hold) begin
            n_hold_key = r_rd_key;
            n_hold_tag = r_rd_tag;
        end
        if (uop.set_j) begin
            n_j = r_i + AW'(1);
        end
        if (uop.scan) begin
            n_j = r_j + AW'(1);
            if (do_swap) begin
                n_hold_key = r_rd_key;
                n_hold_tag = r_rd_tag;
            end
        end
        if (uop.inc_i) begin
            n_i = r_i + AW'(1);
        end
        if (emit_adv) begin
            n_ov    = 1'b1;
            n_okey  = r_rd_key;
            n_otag  = r_rd_tag;
            n_olast = (CW'(r_k) + CW'(1)) == r_cnt;
            n_oovf  = r_ovf;
            n_k     = r_k + AW'(1);
            // set done: clear for the next one
            if ((CW'(r_k) + CW'(1)) == r_cnt) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= S_LOAD;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_desc <= 1'b0;
            r_i    <= '0;
            r_j    <= '0;
            r_k    <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
            r_i   <= n_i;
            r_j   <= n_j;
            r_k   <= n_k;
            r_ov  <= n_ov;
            if (cfg_wr) begin
                r_desc <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_key <= n_hold_key;
        r_hold_tag <= n_hold_tag;
        r_okey     <= n_okey;
        r_otag     <= n_otag;
        r_olast    <= n_olast;
        r_oovf     <= n_oovf;
    end

    assign o_out_valid   = r_ov;
    assign o_sorted_key  = r_okey;
    assign o_sorted_tag  = r_otag;
    assign o_last_result = r_olast;
    assign o_overflowed  = r_oovf;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_SCAN) |-> (r_j > r_i))
        else $error("scan position not past row position");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_adv && n_olast) |=> (r_cnt == '0 && !r_ovf && r_pc == S_LOAD))
        else $error("set state not cleared after final result");

    a_no_load_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc != S_LOAD) |-> (o_in_stall && !wr_en || !in_acc))
        else $error("request taken while sorting");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ese_pkg::*;

    localparam int CAPACITY      = MAX_ITEMS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int PHASE_ITEMS   = 50;

    localparam logic [APB_AW-1:0] ADDR_ORDER  = {REG_DESCENDING, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_UNUSED = {~REG_DESCENDING, 2'b00};

    typedef enum bit {
        ORDER_ASC  = 1'b0,
        ORDER_DESC = 1'b1
    } t_sort_order;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
        logic                    last;
        logic                    ovf;
    } t_sorted_result;

    class t_sort_tracker;
        t_sort_order             order;
        logic signed [KEY_W-1:0] keys[$];
        logic        [TAG_W-1:0] tags[$];
        bit                      dropped;
        t_sorted_result          owed[$];
        int                      errors;
        int                      requests;
        int                      sets;
        int                      overflow_sets;
        int                      checked;

        function new();
            order = ORDER_ASC;
        endfunction

        // store the request; on the last one, sort the set and queue its results
        function void note_request(logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                   logic last);
            t_sorted_result          r;
            logic signed [KEY_W-1:0] tk;
            logic        [TAG_W-1:0] tt;
            bit                      swap;
            int                      n;
            requests++;
            if (keys.size() < CAPACITY) begin
                keys.insert(keys.size(), key);
                tags.insert(tags.size(), tag);
            end else begin
                dropped = 1'b1;
            end
            if (!last) return;
            n = keys.size();
            for (int i = 0; i + 1 < n; i++) begin
                for (int j = i + 1; j < n; j++) begin
                    swap = (order == ORDER_DESC) ? (keys[i] < keys[j]) : (keys[i] > keys[j]);
                    if (swap) begin
                        tk = keys[i];
                        tt = tags[i];
                        keys[i] = keys[j];
                        tags[i] = tags[j];
                        keys[j] = tk;
                        tags[j] = tt;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                r.key  = keys[k];
                r.tag  = tags[k];
                r.last = (k == n - 1);
                r.ovf  = dropped;
                owed.insert(owed.size(), r);
            end
            sets++;
            if (dropped) overflow_sets++;
            keys.delete();
            tags.delete();
            dropped = 1'b0;
        endfunction

        function void check_result(logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                   logic last, logic ovf);
            t_sorted_result e;
            checked++;
            if (owed.size() == 0) begin
                $error("unexpected result: key %0d tag %0h", key, tag);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (key !== e.key) begin
                $error("sorted_key mismatch: expected %0d, got %0d", e.key, key);
                errors++;
            end
            if (tag !== e.tag) begin
                $error("sorted_tag mismatch: expected %0h, got %0h", e.tag, tag);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_result mismatch: expected %0b, got %0b", e.last, last);
                errors++;
            end
            if (ovf !== e.ovf) begin
                $error("overflowed mismatch: expected %0b, got %0b", e.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [KEY_W-1:0] i_item_key;
    logic        [TAG_W-1:0] i_item_tag;
    logic                    i_last_item;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [KEY_W-1:0] o_sorted_key;
    logic        [TAG_W-1:0] o_sorted_tag;
    logic                    o_last_result;
    logic                    o_overflowed;

    t_sort_tracker     tracker;
    bit                quiet;
    int                hold_asks;
    int                holds_served;
    int                hold_left;
    int                cycles;

    exchange_sort_engine_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_item_key    (i_item_key),
        .i_item_tag    (i_item_tag),
        .i_last_item   (i_last_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sorted_key  (o_sorted_key),
        .o_sorted_tag  (o_sorted_tag),
        .o_last_result (o_last_result),
        .o_overflowed  (o_overflowed)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still owed", cycles,
                     tracker.owed.size());
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left == 0 && holds_served != hold_asks) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 22);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(o_sorted_key, o_sorted_tag, o_last_result, o_overflowed);
    end

    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: k = 32'sh8000_0000;
                    1: k = 32'sh7FFF_FFFF;
                    2: k = '0;
                    default: k = -1;
                endcase
            end
            1, 2, 3: begin
                // narrow range so that ties are common
                k = $urandom_range(0, 6);
                k = k - 3;
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic push_item(input logic signed [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                             input logic last);
        while (!quiet && $urandom_range(0, 99) < 22) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_item_key  <= key;
        i_item_tag  <= tag;
        i_last_item <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_request(key, tag, last);
        @(negedge i_clk);
    endtask

    task automatic send_set(input int count);
        for (int idx = 0; idx < count; idx++)
            push_item(pick_key(), TAG_W'($urandom), idx == count - 1);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.owed.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_order_reg();
        logic [APB_DW-1:0] seen;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ORDER;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        seen = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        if (seen !== APB_DW'(tracker.order)) begin
            $error("descending_order mismatch: expected %0h, got %0h",
                   APB_DW'(tracker.order), seen);
            tracker.errors++;
        end
    endtask

    // only legal once the block has gone idle
    task automatic program_order(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        wait_drained();
        apb_write(addr, value);
        if (addr == ADDR_ORDER) tracker.order = t_sort_order'(value[0]);
        check_order_reg();
    endtask

    task automatic run_phase(input int special_size, input bit ask_hold);
        int sent;
        int n;
        sent = 0;
        if (ask_hold) hold_asks++;
        if (special_size > 0) begin
            send_set(special_size);
            sent += special_size;
        end
        while (sent < PHASE_ITEMS) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_set(n);
            sent += n;
        end
    endtask

    initial begin
        tracker     = new();
        quiet       = 1'b0;
        hold_asks   = 0;
        holds_served = 0;
        hold_left   = 0;
        cycles      = 0;
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_in_valid  <= 1'b0;
        i_item_key  <= '0;
        i_item_tag  <= '0;
        i_last_item <= 1'b0;
        i_out_stall <= 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset value, then ascending with extremes, a single-request set and ties
        check_order_reg();
        push_item(32'sh8000_0000, 16'h0000, 1'b1);
        push_item(32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
        push_item(32'sh8000_0000, 16'h0001, 1'b0);
        push_item(32'sh0000_0000, 16'h8000, 1'b0);
        push_item(-32'sd1,        16'h7FFF, 1'b0);
        push_item(32'sh0000_0000, 16'h1234, 1'b0);
        push_item(32'sd5,         16'hAAAA, 1'b1);

        program_order(ADDR_ORDER, APB_DW'(ORDER_DESC));
        push_item(32'sd3, 16'h0001, 1'b0);
        push_item(32'sd3, 16'h0002, 1'b0);
        push_item(32'sd3, 16'h0003, 1'b1);
        push_item(-32'sd1,        16'h5555, 1'b0);
        push_item(32'sh7FFF_FFFF, 16'h0F0F, 1'b0);
        push_item(32'sh8000_0000, 16'hF0F0, 1'b0);
        push_item(32'sd1,         16'h00FF, 1'b1);

        // random sets; a stretch with no idling first
        program_order(ADDR_ORDER, APB_DW'(ORDER_ASC));
        quiet = 1'b1;
        run_phase(0, 1'b0);
        quiet = 1'b0;

        program_order(ADDR_ORDER, APB_DW'(ORDER_DESC));
        run_phase(CAPACITY, 1'b0);

        // upper bits are ignored, and so is the unused address
        program_order(ADDR_ORDER, 32'hFFFF_FFFE);
        program_order(ADDR_UNUSED, 32'h0000_0001);
        run_phase(CAPACITY + 3, 1'b0);

        // long receiver hold-off while requests keep coming
        program_order(ADDR_ORDER, 32'hFFFF_FFFF);
        run_phase(0, 1'b1);

        program_order(ADDR_ORDER, APB_DW'(ORDER_ASC));
        run_phase(0, 1'b0);

        program_order(ADDR_ORDER, APB_DW'(ORDER_DESC));
        run_phase(CAPACITY + 1, 1'b0);

        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("%0d requests in %0d sets (%0d with dropped requests), %0d results checked",
                 tracker.requests, tracker.sets, tracker.overflow_sets, tracker.checked);
        $display("both sort orders, full and overflowing sets, one long output hold-off");
        if (tracker.errors == 0 && tracker.owed.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (tracker.owed.size() != 0)
                $error("%0d expected results never arrived", tracker.owed.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
